[sv/bb3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 edge-aware box blur
// Widths, line buffer depth, the reciprocal table of the rounding divider
// and the word that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package bb3_pkg;

    // Line buffer depth and derived column index width.
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);

    // Configuration register widths, indexes and port width.
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;
    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

    // Pixel and arithmetic widths.
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int SUM_W    = 12;
    localparam int NUM_W    = 13;
    localparam int REC_W    = 14;
    localparam int REC_SH   = 16;
    localparam int PROD_W   = NUM_W + REC_W;
    localparam int QUO_W    = PROD_W - REC_SH;
    localparam int REM_W    = 14;

    // Reciprocals of 2N, scaled by 2^16, for N = 4, 6 and 9.
    localparam logic [REC_W-1:0] REC_8  = 14'd8192;
    localparam logic [REC_W-1:0] REC_12 = 14'd5461;
    localparam logic [REC_W-1:0] REC_18 = 14'd3640;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Divisor selection: corner, edge or inside pixel.
    typedef enum logic [1:0] {
        DEN_8,
        DEN_12,
        DEN_18
    } t_den;

    // One classified word: the new window column and its border flags.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        logic             emit;
        logic             use_left;
        logic             use_right;
        logic             use_top;
        logic             use_bottom;
        logic             last;
    } t_item;

endpackage
`default_nettype wire

[sv/bb3_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_front: input acceptance, position tracking and line buffers
// Tracks input and output positions, decides which words make a result,
// reads and rewrites the two line buffers and pushes one word per pixel.
// ----------------------------------------------------------------------------
module bb3_front
    import bb3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_drain,
    input  wire logic [CH_W-1:0]       i_in_red,
    input  wire logic [CH_W-1:0]       i_in_green,
    input  wire logic [CH_W-1:0]       i_in_blue,
    input  wire logic [FIFO_CW-1:0]    i_fifo_count,
    output logic                       o_push,
    output t_item                      o_item
);

    logic [WID_W-1:0]   r_width;
    logic [HGT_W-1:0]   r_height;
    logic [COL_W-1:0]   r_in_col,  n_in_col;
    logic [1:0]         r_row_cnt, n_row_cnt;
    logic [COL_W-1:0]   r_out_col, n_out_col;
    logic [HGT_W-1:0]   r_out_row, n_out_row;

    logic [WID_W-1:0]   w_eff, w_m1, c_ext, c_inc;
    logic [HGT_W-1:0]   h_eff, h_m1;
    logic [COL_W-1:0]   c;
    logic               accept, emit, last, wrap;
    logic               use_l, use_r, use_t, use_b;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd, r_byp_data, rd, wdata;
    logic               r_byp;
    logic               r_b_valid;
    logic [COL_W-1:0]   r_b_addr;
    logic [PIX_W-1:0]   r_b_pix;
    logic               r_b_emit, r_b_l, r_b_r, r_b_t, r_b_b, r_b_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size, clamped to the supported range.
    always_comb begin
        if (r_width < WID_W'(2))              w_eff = WID_W'(2);
        else if (r_width > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
        else                                  w_eff = r_width;
        h_eff = (r_height < HGT_W'(2)) ? HGT_W'(2) : r_height;
        w_m1  = w_eff - WID_W'(1);
        h_m1  = h_eff - HGT_W'(1);
    end

    // The front holds off when the queue could not take every word in flight.
    assign o_stall = ({1'b0, i_fifo_count} + {{FIFO_CW{1'b0}}, r_b_valid})
                     >= (FIFO_CW+1)'(FIFO_DEPTH);
    assign accept  = i_valid && !o_stall;

    // Position tracking and classification of the incoming word.
    always_comb begin
        c_ext     = ({1'b0, r_in_col} >= w_eff) ? '0 : {1'b0, r_in_col};
        c         = c_ext[COL_W-1:0];
        c_inc     = c_ext + WID_W'(1);
        wrap      = c_inc >= w_eff;
        emit      = (r_row_cnt >= 2'd2) || (r_row_cnt == 2'd1 && c != '0);
        use_l     = r_out_col != '0;
        use_r     = {1'b0, r_out_col} < w_m1;
        use_t     = r_out_row != '0;
        use_b     = r_out_row < h_m1;
        last      = 1'b0;
        n_in_col  = wrap ? '0 : c_inc[COL_W-1:0];
        n_row_cnt = (wrap && r_row_cnt < 2'd2) ? r_row_cnt + 2'd1 : r_row_cnt;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if ({1'b0, r_out_col} >= w_m1) begin
                n_out_col = '0;
                if (r_out_row >= h_m1) last = 1'b1;
                else n_out_row = r_out_row + HGT_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
        if (last) begin
            n_in_col  = '0;
            n_row_cnt = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_row_cnt <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
            if (accept) begin
                r_in_col  <= n_in_col;
                r_row_cnt <= n_row_cnt;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    // Second stage payload: address, pixel and flags of the word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_addr   <= c;
            r_b_pix    <= i_drain ? '0 : {i_in_red, i_in_green, i_in_blue};
            r_b_emit   <= emit;
            r_b_l      <= use_l;
            r_b_r      <= use_r;
            r_b_t      <= use_t;
            r_b_b      <= use_b;
            r_b_last   <= last;
            r_byp      <= r_b_valid && (r_b_addr == c);
            r_byp_data <= wdata;
        end
    end

    // Line buffers: older row in the upper half, newer row in the lower half.
    // A read at the address being written in the same cycle takes the new data.
    assign rd    = r_byp ? r_byp_data : r_rd;
    assign wdata = {rd[PIX_W-1:0], r_b_pix};

    always_ff @(posedge i_clk) begin
        if (r_b_valid) mem[r_b_addr] <= wdata;
        if (accept)    r_rd <= mem[c];
    end

    // Word to the queue.
    assign o_push = r_b_valid;
    always_comb begin
        o_item.top        = rd[2*PIX_W-1:PIX_W];
        o_item.mid        = rd[PIX_W-1:0];
        o_item.bot        = r_b_pix;
        o_item.emit       = r_b_emit;
        o_item.use_left   = r_b_l;
        o_item.use_right  = r_b_r;
        o_item.use_top    = r_b_t;
        o_item.use_bottom = r_b_b;
        o_item.last       = r_b_last;
    end

endmodule
`default_nettype wire

[sv/bb3_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_fifo: short queue between front and back
// A small register queue of classified words; the head is shown directly.
// ----------------------------------------------------------------------------
module bb3_fifo
    import bb3_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire t_item              i_item,
    input  wire logic               i_pop,
    output t_item                   o_item,
    output logic                    o_empty,
    output logic [FIFO_CW-1:0]      o_count
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_CW-1:0] r_count;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + FIFO_AW'(1);
            if (i_pop)  r_rd <= r_rd + FIFO_AW'(1);
            r_count <= r_count + FIFO_CW'(i_push) - FIFO_CW'(i_pop);
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_empty = r_count == '0;
    assign o_count = r_count;

endmodule
`default_nettype wire

[sv/bb3_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_back: window, masked sums, rounding divide and output register
// Shifts the 3x3 window once per word, sums the in-bounds pixels and
// divides by 2N with a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module bb3_back
    import bb3_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_item           i_item,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [CH_W-1:0]      o_out_red,
    output logic [CH_W-1:0]      o_out_green,
    output logic [CH_W-1:0]      o_out_blue,
    output logic                 o_frame_end
);

    logic [2:0][PIX_W-1:0] r_win_m, r_win_r, new_col;
    logic [2:0][SUM_W-1:0] sums, r_p_sum;
    logic                  en;
    logic [1:0]            missing;
    t_den                  den, r_p_den, r_q_den;
    logic                  r_p_valid, r_p_last, r_q_valid, r_q_last;
    logic [2:0][NUM_W-1:0] num, r_q_num;
    logic [2:0][PROD_W-1:0] r_q_prod;
    logic [REC_W-1:0]      recip;
    logic [NUM_W-1:0]      n_cnt;
    logic [2:0][CH_W-1:0]  res;
    logic                  r_out_valid, r_out_last;
    logic [2:0][CH_W-1:0]  r_out;

    // The whole back pipeline moves when the output register is free.
    assign en    = !r_out_valid || !i_stall;
    assign o_pop = !i_empty && en;

    assign new_col = {i_item.bot, i_item.mid, i_item.top};

    // Masked sums over the shifted window, per channel.
    always_comb begin
        logic [SUM_W-1:0] acc;
        for (int ch = 0; ch < 3; ch++) begin
            acc = '0;
            for (int r = 0; r < 3; r++) begin
                if ((r != 0 || i_item.use_top) && (r != 2 || i_item.use_bottom)) begin
                    if (i_item.use_left)
                        acc = acc + SUM_W'(r_win_m[r][ch*CH_W +: CH_W]);
                    acc = acc + SUM_W'(r_win_r[r][ch*CH_W +: CH_W]);
                    if (i_item.use_right)
                        acc = acc + SUM_W'(new_col[r][ch*CH_W +: CH_W]);
                end
            end
            sums[2-ch] = acc;
        end
        missing = 2'(!i_item.use_left) + 2'(!i_item.use_right)
                + 2'(!i_item.use_top) + 2'(!i_item.use_bottom);
        case (missing)
            2'd0:    den = DEN_18;
            2'd1:    den = DEN_12;
            default: den = DEN_8;
        endcase
    end

    // Window shift; the window empties after the last pixel of a frame.
    // The oldest column is dropped by the shift, so only two columns are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_m <= '0;
            r_win_r <= '0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_win_m <= '0;
                r_win_r <= '0;
            end else begin
                r_win_m <= r_win_r;
                r_win_r <= new_col;
            end
        end
    end

    // Numerator 2*sum + N and reciprocal selection.
    always_comb begin
        case (r_p_den)
            DEN_8:   begin recip = REC_8;  n_cnt = NUM_W'(4); end
            DEN_12:  begin recip = REC_12; n_cnt = NUM_W'(6); end
            default: begin recip = REC_18; n_cnt = NUM_W'(9); end
        endcase
        for (int ch = 0; ch < 3; ch++)
            num[ch] = {r_p_sum[ch], 1'b0} + n_cnt;
    end

    // Quotient estimate and one correction step.
    always_comb begin
        logic [QUO_W-1:0] q;
        logic [REM_W-1:0] qd, rem, d;
        for (int ch = 0; ch < 3; ch++) begin
            q = r_q_prod[ch][PROD_W-1:REC_SH];
            case (r_q_den)
                DEN_8: begin
                    qd = REM_W'({q, 3'b000});
                    d  = REM_W'(8);
                end
                DEN_12: begin
                    qd = REM_W'({q, 3'b000}) + REM_W'({q, 2'b00});
                    d  = REM_W'(12);
                end
                default: begin
                    qd = REM_W'({q, 4'b0000}) + REM_W'({q, 1'b0});
                    d  = REM_W'(18);
                end
            endcase
            rem = REM_W'(r_q_num[ch]) - qd;
            if (rem >= d) q = q + QUO_W'(1);
            res[ch] = q[CH_W-1:0];
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p_valid   <= o_pop && i_item.emit;
            r_q_valid   <= r_p_valid;
            r_out_valid <= r_q_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_sum  <= sums;
            r_p_den  <= den;
            r_p_last <= i_item.last;
            for (int ch = 0; ch < 3; ch++)
                r_q_prod[ch] <= num[ch] * recip;
            r_q_num    <= num;
            r_q_den    <= r_p_den;
            r_q_last   <= r_p_last;
            r_out      <= res;
            r_out_last <= r_q_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_frame_end = r_out_last;

    // The window is empty after the last pixel of a frame has been taken.
    a_win_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_win_m == '0 && r_win_r == '0))
        else $error("window not cleared after frame end");

    // The window only moves when a word is taken from the queue.
    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> ($stable(r_win_m) && $stable(r_win_r)))
        else $error("window changed without a word");

    // A finished result reaches the output register when the pipe moves.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_q_valid) |=> r_out_valid)
        else $error("result lost before the output register");

    // Nothing is popped from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

[sv/box_blur_3x3_edge_aware_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top: 3x3 edge-aware box blur over an RGB stream
//
//   channel   direction  handshake          payload
//   config    in         i_cfg_we           i_cfg_index, i_cfg_data
//   pixel in  in         i_valid / o_stall  i_drain, i_in_red/green/blue
//   pixel out out        o_valid / i_stall  o_out_red/green/blue, o_frame_end
//
// One word is taken per clock unless stalled; the line buffer memory has one
// read and one write port, and the read of one word overlaps the write of the
// word before. A result passes the front's second stage, the queue and the
// back's sum, product and output registers. Reset is synchronous and clears
// all control state; the line buffers are not cleared. A stall on the output
// side fills a four-word queue before the input side is held off.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top
    import bb3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_drain,
    input  wire logic [CH_W-1:0]       i_in_red,
    input  wire logic [CH_W-1:0]       i_in_green,
    input  wire logic [CH_W-1:0]       i_in_blue,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [CH_W-1:0]            o_out_red,
    output logic [CH_W-1:0]            o_out_green,
    output logic [CH_W-1:0]            o_out_blue,
    output logic                       o_frame_end
);

    logic               push, pop, empty;
    t_item              push_item, head_item;
    logic [FIFO_CW-1:0] count;

    // Front part: positions, classification and line buffers.
    bb3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_drain      (i_drain),
        .i_in_red     (i_in_red),
        .i_in_green   (i_in_green),
        .i_in_blue    (i_in_blue),
        .i_fifo_count (count),
        .o_push       (push),
        .o_item       (push_item)
    );

    // Queue between the two parts.
    bb3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (empty),
        .o_count (count)
    );

    // Back part: window, sums, divide and output register.
    bb3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_frame_end (o_frame_end)
    );

endmodule
`default_nettype wire

[tb/sv/bb3_blur_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_blur_checker: prediction and comparison for the 3x3 box blur
// Watches the configuration port and both pixel channels. Each accepted input
// word is run through a local model of the line buffers and window, and each
// blurred pixel it produces is queued and compared with the next output word.
// ----------------------------------------------------------------------------
module bb3_blur_checker
    import bb3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic                  i_drain,
    input  wire logic [CH_W-1:0]       i_in_red,
    input  wire logic [CH_W-1:0]       i_in_green,
    input  wire logic [CH_W-1:0]       i_in_blue,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [CH_W-1:0]       i_out_red,
    input  wire logic [CH_W-1:0]       i_out_green,
    input  wire logic [CH_W-1:0]       i_out_blue,
    input  wire logic                  i_frame_end,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } t_blur_px;

    // Local copy of the block state and configuration.
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] newer_row [MAX_WIDTH];
    logic [PIX_W-1:0] window [9];
    int unsigned      col_in;
    int unsigned      rows_done;
    int unsigned      col_out;
    int unsigned      row_out;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    t_blur_px         blurred_q [$];

    assign o_pending = blurred_q.size();

    // Advance the window by one word and queue the blurred pixel, if any.
    task automatic blur_step(input logic drain, input logic [PIX_W-1:0] color);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned n;
        int unsigned sums [3];
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        logic emits;
        logic last;
        t_blur_px res;
        w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < 2) ? 2 : height_reg;
        pix = drain ? '0 : color;
        c = (col_in >= w) ? 0 : col_in;
        top_px = older_row[c];
        mid_px = newer_row[c];
        older_row[c] = mid_px;
        newer_row[c] = pix;
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = top_px;
        window[5] = mid_px;
        window[8] = pix;
        emits = (rows_done >= 2) || (rows_done == 1 && c >= 1);
        if (c + 1 >= w) begin
            col_in = 0;
            if (rows_done < 2) rows_done++;
        end else begin
            col_in = c + 1;
        end
        if (!emits) return;

        // Sum only the neighbors that lie inside the frame.
        n = 0;
        sums = '{0, 0, 0};
        for (int r = 0; r < 3; r++) begin
            if ((r == 0 && row_out == 0) || (r == 2 && row_out >= h - 1)) continue;
            for (int k = 0; k < 3; k++) begin
                if ((k == 0 && col_out == 0) || (k == 2 && col_out >= w - 1)) continue;
                sums[0] += window[r*3+k][23:16];
                sums[1] += window[r*3+k][15:8];
                sums[2] += window[r*3+k][7:0];
                n++;
            end
        end
        res.red   = CH_W'((2 * sums[0] + n) / (2 * n));
        res.green = CH_W'((2 * sums[1] + n) / (2 * n));
        res.blue  = CH_W'((2 * sums[2] + n) / (2 * n));
        last = 1'b0;
        if (col_out >= w - 1) begin
            col_out = 0;
            if (row_out >= h - 1) last = 1'b1;
            else row_out++;
        end else begin
            col_out++;
        end
        res.frame_end = last;
        blurred_q.push_back(res);

        // The frame is complete: counters and window start over.
        if (last) begin
            col_in = 0;
            rows_done = 0;
            col_out = 0;
            row_out = 0;
            for (int i = 0; i < 9; i++) window[i] = '0;
        end
    endtask

    // Compare one field and count a mismatch.
    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
    end

    // All inputs are driven with nonblocking assignments, so the values seen
    // here are the ones present at the edge.
    always @(posedge i_clk) begin
        t_blur_px exp_px;
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) window[i] = '0;
            col_in = 0;
            rows_done = 0;
            col_out = 0;
            row_out = 0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) width_reg = i_cfg_data[WID_W-1:0];
                else height_reg = i_cfg_data[HGT_W-1:0];
            end
            if (i_in_valid && !i_in_stall)
                blur_step(i_drain, {i_in_red, i_in_green, i_in_blue});
            if (i_out_valid && !i_out_stall) begin
                if (blurred_q.size() == 0) begin
                    $display("%0t: unexpected output word, actual %0d %0d %0d %0d", $time,
                             i_out_red, i_out_green, i_out_blue, i_frame_end);
                    o_fail_count++;
                end else begin
                    exp_px = blurred_q.pop_front();
                    check_field("red", exp_px.red, i_out_red);
                    check_field("green", exp_px.green, i_out_green);
                    check_field("blue", exp_px.blue, i_out_blue);
                    check_field("frame_end", exp_px.frame_end, i_frame_end);
                end
            end
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the 3x3 edge-aware box blur
// Sends whole frames of several sizes, each flushed with drain words, with
// random gaps on both channels and one long output hold-off. The checker
// module predicts and compares every blurred pixel.
// ----------------------------------------------------------------------------
module testbench;
    import bb3_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_drain;
    logic [CH_W-1:0]       i_in_red;
    logic [CH_W-1:0]       i_in_green;
    logic [CH_W-1:0]       i_in_blue;
    logic                  o_valid;
    logic                  i_stall;
    logic [CH_W-1:0]       o_out_red;
    logic [CH_W-1:0]       o_out_green;
    logic [CH_W-1:0]       o_out_blue;
    logic                  o_frame_end;
    int                    fail_count;
    int                    pending;

    // Idling is switched off near the end; a long hold-off is requested by
    // bumping hold_request.
    logic calm;
    int   hold_request;
    int   hold_served;
    int   hold_left;
    int   burst_left;
    int   sent_words;

    box_blur_3x3_edge_aware_top i_dut (.*);

    bb3_blur_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_drain(i_drain),
        .i_in_red(i_in_red), .i_in_green(i_in_green), .i_in_blue(i_in_blue),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_red(o_out_red), .i_out_green(o_out_green), .i_out_blue(o_out_blue),
        .i_frame_end(o_frame_end), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_served != hold_request) begin
            hold_served <= hold_request;
            hold_left <= 80;
            i_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            burst_left <= $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic drain, input logic [PIX_W-1:0] color);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_drain    <= drain;
        i_in_red   <= color[23:16];
        i_in_green <= color[15:8];
        i_in_blue  <= color[7:0];
        do @(posedge i_clk); while (o_stall);
    endtask

    // Write a register; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Configure, then send one frame followed by width+1 drain words.
    // Extreme mode draws every channel from 0 and 255 only.
    task automatic send_frame(input int wval, input int hval, input bit extreme,
                              input int drain_odds);
        int w;
        int h;
        logic [PIX_W-1:0] color;
        w = (wval < 2) ? 2 : (wval > MAX_WIDTH) ? MAX_WIDTH : wval;
        h = (hval < 2) ? 2 : hval;
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        write_reg(CFG_WIDTH,
                  (CFG_DATA_W'($urandom_range(0, 3)) << WID_W) | CFG_DATA_W'(wval));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(hval));
        for (int k = 0; k < w * h + w + 1; k++) begin
            color = PIX_W'($urandom);
            if (extreme)
                color = {{8{color[0]}}, {8{color[1]}}, {8{color[2]}}};
            if (k >= w * h)
                send_word(1'b1, color);
            else
                send_word(drain_odds > 0 && $urandom_range(1, drain_odds) == 1, color);
        end
        i_valid <= 1'b0;
        sent_words += w * h + w + 1;
    endtask

    initial begin
        calm = 1'b0;
        hold_request = 0;
        hold_served = 0;
        hold_left = 0;
        burst_left = 0;
        sent_words = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_drain <= 1'b0;
        i_in_red <= '0;
        i_in_green <= '0;
        i_in_blue <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frames with saturated colors, and a drain inside a frame.
        send_frame(2, 2, 1'b1, 0);
        send_frame(3, 3, 1'b1, 4);

        // Out-of-range sizes.
        send_frame(0, 1, 1'b0, 0);
        send_frame(1, 0, 1'b1, 0);

        // A long output hold-off while a mid-size frame keeps coming in.
        hold_request++;
        send_frame(8, 12, 1'b0, 16);

        // Random frames up to the word budget.
        while (sent_words < 1100) begin
            int w;
            int h;
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 8);
            if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1);
            if (sent_words > 950) calm = 1'b1;
            send_frame(w, h, $urandom_range(0, 4) == 0, 32);
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit.
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
sv/bb3_pkg.sv
sv/bb3_front.sv
sv/bb3_fifo.sv
sv/bb3_back.sv
sv/box_blur_3x3_edge_aware_top.sv
tb/sv/bb3_blur_checker.sv
tb/sv/testbench.sv
